[design/soil_moisture_pump_controller_core_macros.svh]
// Assertion macros shared by the pump controller RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SOIL_MOISTURE_PUMP_CONTROLLER_CORE_MACROS_SVH
`define SOIL_MOISTURE_PUMP_CONTROLLER_CORE_MACROS_SVH

// Check that an expression holds at every clock edge.
`define SMPC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SMPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SMPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/smpc_pkg.sv]
// Package for the soil moisture pump controller: item types, codes, reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smpc_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int CMD_W     = 8;
  localparam int TIMER_W   = 16;
  localparam int THRESH_W  = 10;
  localparam int AVG_W     = 10;
  localparam int SUM_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SAMPLES_PER_AVERAGE_DEF = 100;

  localparam logic [THRESH_W-1:0] DRY_THRESHOLD_RST = 10'd500;
  localparam logic [TIMER_W-1:0]  REPORT_PERIOD_RST = 16'd5000;
  localparam logic [TIMER_W-1:0]  PUMP_RUN_RST      = 16'd3000;
  localparam logic [TIMER_W-1:0]  TIMER_MAX         = 16'hFFFF;
  localparam logic [CMD_W-1:0]    CMD_START         = 8'd1;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_COMMAND = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRY_THRESHOLD = 2'd0,
    REG_REPORT_PERIOD = 2'd1,
    REG_PUMP_RUN      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [SAMPLE_W-1:0] sample;
    logic [CMD_W-1:0]    command;
  } in_item_t;

  typedef struct packed {
    logic                pump_active;
    logic                report_valid;
    logic [AVG_W-1:0]    report_value;
  } out_item_t;

endpackage
`default_nettype wire

[design/soil_moisture_pump_controller_core.sv]
// Soil moisture pump controller core; depends on smpc_pkg and the assertion macro header.
// Each item passes through the input register, then the result register; out_valid rises
// when the item moves into the result register, which can wait on a stalled output.
// Throughput: one item per cycle; either side may stall without a bubble.
// Reset (rst_n low, synchronous): pipeline empty, pump off, timers, sums and average at zero,
// configuration registers at 500 / 5000 / 3000.
`timescale 1ns / 1ps
`default_nettype none
`include "soil_moisture_pump_controller_core_macros.svh"
module soil_moisture_pump_controller_core #(
  parameter int SAMPLES_PER_AVERAGE = smpc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // item input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire smpc_pkg::in_item_t               in_data,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output smpc_pkg::out_item_t                   out_data,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [smpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [smpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int N      = SAMPLES_PER_AVERAGE;
  localparam int CNT_W  = $clog2(N + 1);
  // Floor division by N as a multiply by a rounded-up reciprocal: with
  // L = ceil(log2 N) and SHIFT = SUM_W + L the quotient is exact for every
  // SUM_W-bit dividend.
  localparam int DIV_L   = $clog2(N);
  localparam int SHIFT   = smpc_pkg::SUM_W + DIV_L;
  localparam int MUL_W   = smpc_pkg::SUM_W + 2;
  localparam int PROD_W  = smpc_pkg::SUM_W + MUL_W;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + N - 1) / N;
  localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

  // Pipeline registers.
  logic                 in_vld_r;
  smpc_pkg::in_item_t   in_r;
  logic                 out_vld_r;
  smpc_pkg::out_item_t  out_r;

  // Configuration registers.
  logic [smpc_pkg::THRESH_W-1:0] dry_threshold_r;
  logic [smpc_pkg::TIMER_W-1:0]  report_period_r;
  logic [smpc_pkg::TIMER_W-1:0]  pump_run_r;

  // Controller state. The completed block sum is held rather than the average;
  // the average is derived from it with one multiply when a report needs it.
  logic [smpc_pkg::SUM_W-1:0]    sample_sum_r, sample_sum_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [smpc_pkg::SUM_W-1:0]    held_sum_r, held_sum_nxt;
  logic [smpc_pkg::TIMER_W-1:0]  report_timer_r, report_timer_nxt;
  logic [smpc_pkg::TIMER_W-1:0]  pump_timer_r, pump_timer_nxt;
  logic                          pump_on_r, pump_on_nxt;

  logic                          out_free;
  logic                          advance;
  logic [PROD_W-1:0]             avg_prod;
  logic [smpc_pkg::AVG_W-1:0]    held_avg;
  logic [smpc_pkg::SUM_W-1:0]    sum_add;
  logic [CNT_W:0]                cnt_inc;
  logic [smpc_pkg::TIMER_W-1:0]  pump_tick;
  logic [smpc_pkg::TIMER_W-1:0]  report_tick;
  smpc_pkg::out_item_t           result;

  // Handshake: the result register frees when empty or being taken; the input
  // register moves its item on whenever the result register frees.
  assign out_free  = !out_vld_r || out_ready;
  assign advance   = in_vld_r && out_free;
  assign in_ready  = !in_vld_r || out_free;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Average of the last completed block.
  assign avg_prod = PROD_W'(held_sum_r) * PROD_W'(RECIP_C);
  assign held_avg = avg_prod[SHIFT +: smpc_pkg::AVG_W];

  assign sum_add     = sample_sum_r + smpc_pkg::SUM_W'(in_r.sample);
  assign cnt_inc     = {1'b0, count_r} + (CNT_W + 1)'(1);
  assign pump_tick   = (pump_timer_r == smpc_pkg::TIMER_MAX) ? pump_timer_r
                       : pump_timer_r + smpc_pkg::TIMER_W'(1);
  assign report_tick = (report_timer_r == smpc_pkg::TIMER_MAX) ? report_timer_r
                       : report_timer_r + smpc_pkg::TIMER_W'(1);

  // Single-pass update for the item held in the input register.
  always_comb begin
    sample_sum_nxt   = sample_sum_r;
    count_nxt        = count_r;
    held_sum_nxt     = held_sum_r;
    report_timer_nxt = report_timer_r;
    pump_timer_nxt   = pump_timer_r;
    pump_on_nxt      = pump_on_r;
    result.report_valid = 1'b0;
    result.report_value = '0;
    case (in_r.operation)
      smpc_pkg::OP_SAMPLE: begin
        // Accumulate; on the last sample of a block latch the sum and restart.
        if (cnt_inc >= (CNT_W + 1)'(N)) begin
          held_sum_nxt   = sum_add;
          sample_sum_nxt = '0;
          count_nxt      = '0;
        end else begin
          sample_sum_nxt = sum_add;
          count_nxt      = cnt_inc[CNT_W-1:0];
        end
      end
      smpc_pkg::OP_TICK: begin
        // Pump stop first, then the report check, which may restart the pump.
        pump_timer_nxt = pump_tick;
        if (pump_on_r && (pump_tick >= pump_run_r)) begin
          pump_on_nxt = 1'b0;
        end
        report_timer_nxt = report_tick;
        if (report_tick >= report_period_r) begin
          // Subtract rather than clear so a lowered period catches up.
          report_timer_nxt    = report_tick - report_period_r;
          result.report_valid = 1'b1;
          result.report_value = held_avg;
          if (held_avg < dry_threshold_r) begin
            pump_on_nxt    = 1'b1;
            pump_timer_nxt = '0;
          end
        end
      end
      smpc_pkg::OP_COMMAND: begin
        if (in_r.command == smpc_pkg::CMD_START) begin
          pump_on_nxt    = 1'b1;
          pump_timer_nxt = '0;
        end
      end
      default: begin
        // Unused operation code: state holds, answer with the pump state.
      end
    endcase
    result.pump_active = pump_on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      dry_threshold_r <= smpc_pkg::DRY_THRESHOLD_RST;
      report_period_r <= smpc_pkg::REPORT_PERIOD_RST;
      pump_run_r      <= smpc_pkg::PUMP_RUN_RST;
      sample_sum_r    <= '0;
      count_r         <= '0;
      held_sum_r      <= '0;
      report_timer_r  <= '0;
      pump_timer_r    <= '0;
      pump_on_r       <= 1'b0;
    end else begin
      // Input register: load a new item, or drop the one just processed.
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      // Result register: load on advance, drop once taken.
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      // State commits only when the item moves into the result register.
      if (advance) begin
        sample_sum_r   <= sample_sum_nxt;
        count_r        <= count_nxt;
        held_sum_r     <= held_sum_nxt;
        report_timer_r <= report_timer_nxt;
        pump_timer_r   <= pump_timer_nxt;
        pump_on_r      <= pump_on_nxt;
      end
      // Configuration writes; unknown indexes are ignored.
      if (cfg_valid) begin
        case (cfg_index)
          smpc_pkg::REG_DRY_THRESHOLD: dry_threshold_r <= cfg_data[smpc_pkg::THRESH_W-1:0];
          smpc_pkg::REG_REPORT_PERIOD: report_period_r <= cfg_data;
          smpc_pkg::REG_PUMP_RUN:      pump_run_r      <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  `SMPC_ASSERT_IMP(a_dry_report_runs_pump, out_vld_r && out_r.report_valid && (out_r.report_value < dry_threshold_r), out_r.pump_active, "dry report left pump off")
  `SMPC_ASSERT_IMP(a_value_only_on_report, out_vld_r && !out_r.report_valid, out_r.report_value == '0, "report value without report")
  `SMPC_ASSERT_ALWAYS(a_count_in_block, count_r < CNT_W'(N), "sample count past block size")
  `SMPC_ASSERT_NEXT(a_stalled_item_held, in_vld_r && !out_free, in_vld_r && (in_r == $past(in_r)), "stalled input item lost")

endmodule
`default_nettype wire

[verif/soil_moisture_pump_controller_core_test.sv]
// Self-checking testbench for soil_moisture_pump_controller_core: directed table, random
// field phases and a back-to-back tick soak, checked against an in-bench model or pinned results.
// Depends on smpc_pkg and the core RTL only.
`timescale 1ns / 1ps
module soil_moisture_pump_controller_core_test;
  import smpc_pkg::*;

  localparam int AVG_SAMPLES  = SAMPLES_PER_AVERAGE_DEF;
  localparam int PIPE_LATENCY = 2;
  localparam int STALL_LIMIT  = 2000;
  localparam int FIELD_PHASES = 8;
  localparam int PHASE_ITEMS  = 96;
  localparam int SOAK_TICKS   = 50;

  // Codes the package leaves unnamed: the spare operation and the spare register slot.
  localparam logic [1:0]           OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One row of the directed plan: either an item or a register write. Pinned rows carry
  // the result read straight off the spec, which replaces the model's forecast.
  typedef struct {
    bit                    is_cfg;
    in_item_t              item;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                    pinned;
    out_item_t             pinned_res;
  } plan_step_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Pinned expectation travels alongside the item so the monitor sees both at accept.
  logic      pin_on  = 1'b0;
  out_item_t pin_res = '0;

  // Model state, reset values as the block comes out of reset.
  logic [THRESH_W-1:0] dry_limit    = DRY_THRESHOLD_RST;
  logic [TIMER_W-1:0]  report_every = REPORT_PERIOD_RST;
  logic [TIMER_W-1:0]  run_limit    = PUMP_RUN_RST;
  logic [SUM_W-1:0]    moist_sum    = '0;
  logic [6:0]          moist_cnt    = '0;
  logic [AVG_W-1:0]    moist_avg    = '0;
  logic [TIMER_W-1:0]  report_clock = '0;
  logic [TIMER_W-1:0]  run_clock    = '0;
  logic                pump_on      = 1'b0;

  out_item_t pump_results_due[$];
  out_item_t forecast;
  out_item_t oldest;
  plan_step_t plan[$];

  bit idling_on       = 1'b1;
  int items_sent      = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;
  int reports_seen    = 0;
  int averages_formed = 0;
  int reg_writes      = 0;

  soil_moisture_pump_controller_core #(
    .SAMPLES_PER_AVERAGE(AVG_SAMPLES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the controller model by one item and return the result it owes.
  // Tick order matters: stop the pump first, then run the report check, which may
  // restart it on the same tick.
  task predict_pump_step(input in_item_t it, output out_item_t res);
    res = '0;
    case (it.operation)
      OP_SAMPLE: begin
        moist_sum = moist_sum + {{(SUM_W - SAMPLE_W){1'b0}}, it.sample};
        moist_cnt = moist_cnt + 7'd1;
        if (moist_cnt >= AVG_SAMPLES) begin
          moist_avg = AVG_W'(moist_sum / AVG_SAMPLES);
          moist_sum = '0;
          moist_cnt = '0;
          averages_formed++;
        end
      end
      OP_TICK: begin
        // Both timers hold at full scale; the pump timer counts even with the pump off.
        if (run_clock != TIMER_MAX) run_clock = run_clock + 16'd1;
        if (pump_on && run_clock >= run_limit) pump_on = 1'b0;
        if (report_clock != TIMER_MAX) report_clock = report_clock + 16'd1;
        // Subtract rather than clear, so a lowered period catches up over later ticks.
        if (report_clock >= report_every) begin
          report_clock = report_clock - report_every;
          res.report_valid = 1'b1;
          res.report_value = moist_avg;
          reports_seen++;
          if (moist_avg < dry_limit) begin
            pump_on   = 1'b1;
            run_clock = '0;
          end
        end
      end
      OP_COMMAND: begin
        // Only the start byte does anything; it also restarts a running pump.
        if (it.command == CMD_START) begin
          pump_on   = 1'b1;
          run_clock = '0;
        end
      end
      default: ;
    endcase
    res.pump_active = pump_on;
  endtask

  task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: forecast on every accepted item, compare every accepted result in order,
  // and track register writes so the model follows the block's settings.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_pump_step(in_data, forecast);
        pump_results_due.push_back(pin_on ? pin_res : forecast);
      end
      if (out_valid && out_ready) begin
        if (pump_results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, out_data);
        end else begin
          oldest = pump_results_due.pop_front();
          check_field("pump_active", 16'(oldest.pump_active), 16'(out_data.pump_active));
          check_field("report_valid", 16'(oldest.report_valid), 16'(out_data.report_valid));
          check_field("report_value", 16'(oldest.report_value), 16'(out_data.report_value));
        end
        results_checked++;
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_DRY_THRESHOLD: dry_limit    = cfg_data[THRESH_W-1:0];
          REG_REPORT_PERIOD: report_every = cfg_data;
          REG_PUMP_RUN:      run_limit    = cfg_data;
          default: ;
        endcase
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
    end
  end

  // Watchdog: end the run once nothing has moved on any channel for too long.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: stall in bursts of random length, otherwise stay ready for a stretch.
  always begin
    @(posedge clk);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(posedge clk);
    end else begin
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 30)) @(posedge clk);
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, int smp, int cmd);
    in_item_t it;
    it.operation = op;
    it.sample    = SAMPLE_W'(smp);
    it.command   = CMD_W'(cmd);
    return it;
  endfunction

  function automatic plan_step_t item_step(logic [1:0] op, int smp, int cmd, bit pinned,
                                           logic pump, logic rep);
    plan_step_t s;
    s = '{default: '0};
    s.item       = make_item(op, smp, cmd);
    s.pinned     = pinned;
    s.pinned_res = '{pump_active: pump, report_valid: rep, report_value: '0};
    return s;
  endfunction

  function automatic plan_step_t cfg_step(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    plan_step_t s;
    s = '{default: '0};
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // Hold the item on the channel until it is taken.
  task send_item(input in_item_t it, input bit pinned, input out_item_t pres);
    in_valid <= 1'b1;
    in_data  <= it;
    pin_on   <= pinned;
    pin_res  <= pres;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Sender gap: drop valid for a burst of random length now and then.
  task pause_sender();
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Stop sending and hold until every forecast result has come back.
  task settle();
    in_valid <= 1'b0;
    while (results_checked < items_sent) @(posedge clk);
  endtask

  task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task apply_settings(input logic [CFG_DATA_W-1:0] thresh, input logic [CFG_DATA_W-1:0] period,
                      input logic [CFG_DATA_W-1:0] run);
    settle();
    cfg_write(REG_DRY_THRESHOLD, thresh);
    cfg_write(REG_REPORT_PERIOD, period);
    cfg_write(REG_PUMP_RUN, run);
    cfg_valid <= 1'b0;
  endtask

  // Random phase: mostly samples clustered around one soil level so averages land on
  // both sides of the threshold, ticks to drive the timers, a few commands and spares.
  task field_phase(input int count);
    int center;
    int lvl;
    int pick;
    in_item_t it;
    center = $urandom_range(0, 1023);
    repeat (count) begin
      it = make_item(OP_TICK, $urandom_range(0, 1023), $urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        it.operation = OP_SAMPLE;
        lvl = center + int'($urandom_range(0, 120)) - 60;
        if (lvl < 0) lvl = 0;
        if (lvl > 1023) lvl = 1023;
        case ($urandom_range(0, 9))
          0:       it.sample = '0;
          1:       it.sample = '1;
          default: it.sample = SAMPLE_W'(lvl);
        endcase
      end else if (pick < 93) begin
        it.operation = OP_TICK;
      end else if (pick < 98) begin
        it.operation = OP_COMMAND;
        if ($urandom_range(0, 2) != 0) it.command = CMD_START;
      end else begin
        it.operation = OP_SPARE;
      end
      send_item(it, 1'b0, '0);
      pause_sender();
    end
  endtask

  initial begin
    bit cfg_open;
    cfg_open = 1'b0;

    // Directed plan. Reset settings first: ignored bytes, spare operation carrying a
    // start byte, the start byte, sample extremes.
    plan.push_back(item_step(OP_TICK, 0, 0, 1'b1, 1'b0, 1'b0));
    plan.push_back(item_step(OP_COMMAND, 0, 0, 1'b1, 1'b0, 1'b0));
    plan.push_back(item_step(OP_COMMAND, 0, 255, 1'b1, 1'b0, 1'b0));
    plan.push_back(item_step(OP_SPARE, 1023, 1, 1'b1, 1'b0, 1'b0));
    plan.push_back(item_step(OP_COMMAND, 1023, 1, 1'b1, 1'b1, 1'b0));
    plan.push_back(item_step(OP_COMMAND, 0, 2, 1'b1, 1'b1, 1'b0));
    plan.push_back(item_step(OP_SAMPLE, 1023, 255, 1'b1, 1'b1, 1'b0));
    plan.push_back(item_step(OP_SAMPLE, 0, 0, 1'b1, 1'b1, 1'b0));
    plan.push_back(item_step(OP_TICK, 512, 1, 1'b1, 1'b1, 1'b0));
    // Full threshold with junk above bit 9, short period and run, spare register slot.
    plan.push_back(cfg_step(REG_DRY_THRESHOLD, 16'hFFFF));
    plan.push_back(cfg_step(REG_REPORT_PERIOD, 16'd2));
    plan.push_back(cfg_step(REG_PUMP_RUN, 16'd1));
    plan.push_back(cfg_step(REG_SPARE, 16'h5A5A));
    // Stop and report-restart on the same tick.
    plan.push_back(item_step(OP_TICK, 0, 0, 1'b0, 1'b0, 1'b0));
    plan.push_back(item_step(OP_TICK, 0, 0, 1'b0, 1'b0, 1'b0));
    plan.push_back(item_step(OP_COMMAND, 0, 1, 1'b1, 1'b1, 1'b0));
    // Zero period and zero run time, threshold at 0 so reports never start the pump.
    plan.push_back(cfg_step(REG_DRY_THRESHOLD, 16'd0));
    plan.push_back(cfg_step(REG_REPORT_PERIOD, 16'd0));
    plan.push_back(cfg_step(REG_PUMP_RUN, 16'd0));
    plan.push_back(item_step(OP_TICK, 0, 0, 1'b1, 1'b0, 1'b1));
    plan.push_back(item_step(OP_TICK, 1023, 255, 1'b1, 1'b0, 1'b1));
    plan.push_back(item_step(OP_COMMAND, 0, 1, 1'b1, 1'b1, 1'b0));
    plan.push_back(item_step(OP_TICK, 0, 0, 1'b1, 1'b0, 1'b1));
    // Raise the period, still under the running count: catch-up reports on following ticks.
    plan.push_back(cfg_step(REG_REPORT_PERIOD, 16'd2));
    plan.push_back(item_step(OP_TICK, 0, 0, 1'b0, 1'b0, 1'b0));
    plan.push_back(item_step(OP_TICK, 0, 0, 1'b0, 1'b0, 1'b0));
    plan.push_back(item_step(OP_TICK, 0, 0, 1'b0, 1'b0, 1'b0));
    // Full-scale period and run time.
    plan.push_back(cfg_step(REG_DRY_THRESHOLD, 16'h03FF));
    plan.push_back(cfg_step(REG_REPORT_PERIOD, 16'hFFFF));
    plan.push_back(cfg_step(REG_PUMP_RUN, 16'hFFFF));
    plan.push_back(item_step(OP_TICK, 0, 0, 1'b0, 1'b0, 1'b0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the plan; register writes wait for the pipeline to drain.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!cfg_open) settle();
        cfg_write(plan[i].reg_idx, plan[i].reg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        send_item(plan[i].item, plan[i].pinned, plan[i].pinned_res);
        pause_sender();
      end
    end

    // Random phases, the first three at the extremes of each register.
    for (int p = 0; p < FIELD_PHASES; p++) begin
      case (p)
        0:       apply_settings(16'd0, 16'd1, 16'd1);
        1:       apply_settings(16'hFFFF, 16'd0, 16'd0);
        2:       apply_settings(16'($urandom), 16'hFFFF, 16'hFFFF);
        default: apply_settings(16'($urandom), 16'($urandom_range(1, 40)),
                                16'($urandom_range(0, 30)));
      endcase
      field_phase(PHASE_ITEMS);
    end

    // Soak with no idling: back-to-back ticks with a zero period, then raise the period
    // under the grown report count so catch-up reports follow on the last ticks.
    idling_on = 1'b0;
    apply_settings(16'd0, 16'd0, 16'hFFFF);
    send_item(make_item(OP_COMMAND, 0, 1), 1'b0, '0);
    repeat (SOAK_TICKS)
      send_item(make_item(OP_TICK, $urandom_range(0, 1023), $urandom_range(0, 255)), 1'b0, '0);
    apply_settings(16'h03FF, 16'd20, 16'd5);
    repeat (8)
      send_item(make_item(OP_TICK, $urandom_range(0, 1023), $urandom_range(0, 255)), 1'b0, '0);

    settle();
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    if (pump_results_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived, expected 0, actual %0d",
               $time, pump_results_due.size(), pump_results_due.size());
    end

    $display("Run covered %0d items and %0d register writes: %0d reports, %0d averages.",
             items_sent, reg_writes, reports_seen, averages_formed);
    $display("%0d results compared, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
